// ===== sv/lavm_pkg.sv =====
// lavm_pkg: types, constants and small helpers for the look-at matrix core
// no dependencies
`default_nettype none

package lavm_pkg;

  localparam int unsigned QW = 32;
  localparam logic signed [QW-1:0] ONE_Q = 32'sd65536;

  // configuration register indexes
  localparam logic [1:0] REG_UP_X = 2'd0;
  localparam logic [1:0] REG_UP_Y = 2'd1;
  localparam logic [1:0] REG_UP_Z = 2'd2;

  localparam logic OP_VIEW  = 1'b0;
  localparam logic OP_WORLD = 1'b1;

  typedef struct packed {
    logic              op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               degenerate;
    logic               last_row;
  } out_item_t;

  // queued job between front and back
  typedef struct packed {
    logic               op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
  } job_t;

  // saturate a 66 bit value into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lavm_front.sv =====
// lavm_front: accepts items, forms pos - target, holds a two-entry job queue
// depends on lavm_pkg
`default_nettype none

module lavm_front import lavm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          job_valid_o,
  input  wire logic     job_take_i,
  output job_t          job_o
);

  job_t       q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;
  job_t       nj;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_take_i && job_valid_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_q[rd_q];

  // classify: keep op, position and exact difference
  always_comb begin
    nj.op = in_data_i.op;
    nj.px = in_data_i.pos_x;
    nj.py = in_data_i.pos_y;
    nj.pz = in_data_i.pos_z;
    nj.dx = 33'(in_data_i.pos_x) - 33'(in_data_i.target_x);
    nj.dy = 33'(in_data_i.pos_y) - 33'(in_data_i.target_y);
    nj.dz = 33'(in_data_i.pos_z) - 33'(in_data_i.target_z);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= nj;
  end

endmodule

`default_nettype wire

// ===== sv/lavm_norm.sv =====
// lavm_norm: multicycle vector normaliser, bit-serial sqrt and division
// depends on lavm_pkg
`default_nettype none

module lavm_norm import lavm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [65:0] v0_i,
  input  wire logic signed [65:0] v1_i,
  input  wire logic signed [65:0] v2_i,
  output logic                    done_o,
  output logic                    zero_o,
  output logic signed [31:0]      o0_o,
  output logic signed [31:0]      o1_o,
  output logic signed [31:0]      o2_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_SQ, S_SQRT, S_DIV
  } state_e;

  state_e       state_q;
  logic [65:0]  m_q [3];
  logic [2:0]   neg_q;
  logic [1:0]   idx_q;
  logic [61:0]  sum_q;
  logic [61:0]  rem_q;
  logic [63:0]  res_q;
  logic [5:0]   cnt_q;
  logic [46:0]  dr_q;
  logic [46:0]  dn_q;
  logic [16:0]  qt_q;
  logic [31:0]  len_q;
  logic signed [31:0] o_q [3];
  logic         zero_q;
  logic         done_q;

  logic [65:0]  mx;
  logic [65:0]  a0, a1, a2;
  logic [63:0]  bitv;
  logic [63:0]  trial;
  logic [47:0]  dtrial;

  assign a0 = v0_i[65] ? 66'(-v0_i) : 66'(v0_i);
  assign a1 = v1_i[65] ? 66'(-v1_i) : 66'(v1_i);
  assign a2 = v2_i[65] ? 66'(-v2_i) : 66'(v2_i);
  assign mx = m_q[0] | m_q[1] | m_q[2];
  assign bitv  = 64'd1 << {cnt_q[4:0], 1'b0};
  assign trial = res_q + bitv;
  assign dtrial = {dr_q, dn_q[46]} - {16'd0, len_q};

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign o0_o = o_q[0];
  assign o1_o = o_q[1];
  assign o2_o = o_q[2];

  // one shift, one square-accumulate, one root bit or one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_IDLE && start_i && (a0 | a1 | a2) == '0) ||
                (state_q == S_DIV && cnt_q == 6'd1 && idx_q == 2'd2);
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            m_q[0] <= a0; m_q[1] <= a1; m_q[2] <= a2;
            neg_q <= {v2_i[65], v1_i[65], v0_i[65]};
            if ((a0 | a1 | a2) == '0) begin
              zero_q <= 1'b1;
              o_q[0] <= '0; o_q[1] <= '0; o_q[2] <= '0;
            end else begin
              zero_q  <= 1'b0;
              state_q <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          // or of magnitudes has same top bit as the max
          if (mx >= 66'(64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if (mx < 66'(64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            sum_q   <= '0;
            idx_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sum_q <= sum_q + 62'(m_q[idx_q][29:0] * m_q[idx_q][29:0]);
          if (idx_q == 2'd2) begin
            // remainder of the root loads as the sum is finished
            rem_q   <= sum_q + 62'(m_q[idx_q][29:0] * m_q[idx_q][29:0]);
            state_q <= S_SQRT;
            cnt_q   <= 6'd30;
            res_q   <= '0;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        S_SQRT: begin
          // sum is below 2^62, so root bits start at 2^60
          if ({2'b0, rem_q} >= trial) begin
            rem_q <= rem_q - 62'(trial);
            res_q <= (res_q >> 1) + bitv;
          end else begin
            res_q <= res_q >> 1;
          end
          if (cnt_q == 6'd0) begin
            state_q <= S_DIV;
            idx_q   <= '0;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) begin
            len_q <= res_q[31:0];
            dr_q  <= '0;
            dn_q  <= {1'b0, m_q[idx_q][29:0], 16'd0};
            qt_q  <= '0;
            cnt_q <= 6'd47;
          end else begin
            if (!dtrial[47]) begin
              dr_q <= dtrial[46:0];
              qt_q <= {qt_q[15:0], 1'b1};
            end else begin
              dr_q <= {dr_q[45:0], dn_q[46]};
              qt_q <= {qt_q[15:0], 1'b0};
            end
            dn_q <= dn_q << 1;
            if (cnt_q == 6'd1) begin
              o_q[idx_q] <= neg_q[idx_q] ? -32'({15'd0, qt_q[15:0], !dtrial[47]})
                                         : 32'({15'd0, qt_q[15:0], !dtrial[47]});
              if (idx_q == 2'd2) begin
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx_q + 2'd1;
              end
            end
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/lavm_back.sv =====
// lavm_back: cross products, normalising, dot products and row output
// depends on lavm_pkg and lavm_norm
`default_nettype none

module lavm_back import lavm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_take_o,
  input  wire job_t               job_i,
  input  wire logic signed [31:0] up_x_i,
  input  wire logic signed [31:0] up_y_i,
  input  wire logic signed [31:0] up_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_NZ, S_CX, S_NX, S_CY, S_NY, S_DOT, S_EMIT
  } state_e;

  state_e       state_q;
  job_t         job_q;
  logic signed [31:0] ax_q [3][3];
  logic signed [65:0] c_q [3];
  logic signed [65:0] acc_q;
  logic signed [31:0] dot_q [3];
  logic [1:0]   k_q;
  logic [1:0]   j_q;
  logic [1:0]   row_q;
  logic         deg_q;
  logic         nstart_q;
  logic         ov_q;
  out_item_t    od_q;

  logic               ndone, nzero;
  logic signed [31:0] n0, n1, n2;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] cross_a [3];
  logic signed [31:0] cross_b [3];
  logic signed [31:0] rc [4];
  logic               out_free;

  lavm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nstart_q),
    .v0_i    (c_q[0]),
    .v1_i    (c_q[1]),
    .v2_i    (c_q[2]),
    .done_o  (ndone),
    .zero_o  (nzero),
    .o0_o    (n0),
    .o1_o    (n1),
    .o2_o    (n2)
  );

  assign out_free    = !ov_q || !out_stall_i;
  assign job_take_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  // operand select for the shared 32x32 multiplier
  always_comb begin
    if (state_q == S_CX) begin
      cross_a[0] = up_x_i; cross_a[1] = up_y_i; cross_a[2] = up_z_i;
      cross_b[0] = ax_q[2][0]; cross_b[1] = ax_q[2][1]; cross_b[2] = ax_q[2][2];
    end else begin
      cross_a[0] = ax_q[2][0]; cross_a[1] = ax_q[2][1]; cross_a[2] = ax_q[2][2];
      cross_b[0] = ax_q[0][0]; cross_b[1] = ax_q[0][1]; cross_b[2] = ax_q[0][2];
    end
    ma = '0; mb = '0;
    if (state_q == S_DOT) begin
      case (j_q)
        2'd0: ma = job_q.px;
        2'd1: ma = job_q.py;
        default: ma = job_q.pz;
      endcase
      mb = ax_q[k_q][j_q];
    end else begin
      // k_q = component, j_q[0] picks the two terms
      case (k_q)
        2'd0: begin
          ma = j_q[0] ? cross_a[2] : cross_a[1];
          mb = j_q[0] ? cross_b[1] : cross_b[2];
        end
        2'd1: begin
          ma = j_q[0] ? cross_a[0] : cross_a[2];
          mb = j_q[0] ? cross_b[2] : cross_b[0];
        end
        default: begin
          ma = j_q[0] ? cross_a[1] : cross_a[0];
          mb = j_q[0] ? cross_b[0] : cross_b[1];
        end
      endcase
    end
    prod = ma * mb;
    for (int c = 0; c < 3; c++) begin
      if (row_q == 2'd3) begin
        rc[c] = (job_q.op == OP_WORLD)
                ? sat32(-66'(c == 0 ? job_q.px : c == 1 ? job_q.py : job_q.pz))
                : dot_q[c];
      end else begin
        rc[c] = (job_q.op == OP_WORLD) ? ax_q[row_q][c] : ax_q[c][row_q];
      end
    end
    rc[3] = (row_q == 2'd3) ? ONE_Q : '0;
  end

  // sequencer over the three axes, the dots and the four rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nstart_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      nstart_q <= (state_q == S_IDLE && job_valid_i) ||
                  ((state_q == S_CX || state_q == S_CY) && j_q[0] && k_q == 2'd2);
      if (state_q == S_EMIT && out_free) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q    <= job_i;
            c_q[0]   <= 66'(job_i.dx);
            c_q[1]   <= 66'(job_i.dy);
            c_q[2]   <= 66'(job_i.dz);
            deg_q    <= 1'b0;
            state_q  <= S_NZ;
          end
        end
        S_NZ, S_NX, S_NY: begin
          if (ndone) begin
            deg_q <= deg_q | nzero;
            k_q   <= '0;
            j_q   <= '0;
            acc_q <= '0;
            if (state_q == S_NZ) begin
              ax_q[2][0] <= n0; ax_q[2][1] <= n1; ax_q[2][2] <= n2;
              state_q <= S_CX;
            end else if (state_q == S_NX) begin
              ax_q[0][0] <= n0; ax_q[0][1] <= n1; ax_q[0][2] <= n2;
              state_q <= S_CY;
            end else begin
              ax_q[1][0] <= n0; ax_q[1][1] <= n1; ax_q[1][2] <= n2;
              state_q <= S_DOT;
            end
          end
        end
        S_CX, S_CY: begin
          if (!j_q[0]) begin
            acc_q <= 66'(prod);
            j_q   <= 2'd1;
          end else begin
            c_q[k_q] <= acc_q - 66'(prod);
            j_q <= 2'd0;
            if (k_q == 2'd2) begin
              state_q  <= (state_q == S_CX) ? S_NX : S_NY;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_DOT: begin
          if (j_q == 2'd2) begin
            acc_q <= '0;
            j_q   <= '0;
            dot_q[k_q] <= sat32(-((acc_q + 66'(prod)) >>> 16));
            if (k_q == 2'd2) begin
              row_q   <= '0;
              state_q <= S_EMIT;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            acc_q <= acc_q + 66'(prod);
            j_q   <= j_q + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            od_q.row_index  <= row_q;
            od_q.col0       <= rc[0];
            od_q.col1       <= rc[1];
            od_q.col2       <= rc[2];
            od_q.col3       <= rc[3];
            od_q.degenerate <= deg_q;
            od_q.last_row   <= (row_q == 2'd3);
            row_q <= row_q + 2'd1;
            if (row_q == 2'd3) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/look_at_view_matrix_core.sv =====
// look_at_view_matrix_core: top level, configuration registers, front and back
// depends on lavm_pkg, lavm_front, lavm_back
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/stall   | in_item_t
//  out     | output    | out_valid/stall  | out_item_t
//  cfg     | input     | valid/ready      | index, 32 bit data
//
// an item passes through three normalisations, each made of normalising shift
// steps, a serial square root (31 steps) and three serial 16.16 divisions; a
// zero-length axis is quicker
// one shared 32x32 multiplier forms cross and dot products
// a two-entry queue accepts new items while the back end works
// reset clears control only; up vector returns to (0, 1.0, 0)
`default_nettype none

module look_at_view_matrix_core import lavm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic signed [31:0] up_x_q, up_y_q, up_z_q;
  logic jv, jt;
  job_t job;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_x_q <= '0;
      up_y_q <= ONE_Q;
      up_z_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UP_X: up_x_q <= cfg_data_i;
        REG_UP_Y: up_y_q <= cfg_data_i;
        REG_UP_Z: up_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lavm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (jv),
    .job_take_i  (jt),
    .job_o       (job)
  );

  lavm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (jv),
    .job_take_o  (jt),
    .job_i       (job),
    .up_x_i      (up_x_q),
    .up_y_i      (up_y_q),
    .up_z_i      (up_z_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // rows leave in order, last row flag only on row three
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_row == (out_data_o.row_index == 2'd3)))
    else $error("last_row mismatch");

  // fourth row carries 1.0 in col3
  a_col3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_row) |-> (out_data_o.col3 == ONE_Q))
    else $error("col3 of last row wrong");

  // after a row is taken, the next row index follows within the item
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last_row ##1 out_valid_o)
      |-> (out_data_o.row_index == $past(out_data_o.row_index) + 2'd1))
    else $error("row order broken");

endmodule

`default_nettype wire
